// ===== src/sli_pkg.sv =====
// Shared constants, codes and types of the sorted list block.
package sli_pkg;

  localparam int DEPTH   = 16;
  localparam int VALUE_W = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int TOTAL_W = 5;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_DELETE = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  // Update command broadcast to every cell in the update cycle.
  typedef struct packed {
    logic ins;   // open a slot at the boundary and shift the tail right
    logic del;   // close the slot at the boundary and shift the tail left
  } cell_cmd_t;

endpackage

// ===== src/sli_cell.sv =====
// One entry of the sorted chain: compare against the request word, then shift or hold.
module sli_cell (
  input  logic                                clk,
  input  logic                                cmp_en,
  input  logic                                occupied,
  input  logic signed [sli_pkg::VALUE_W-1:0]  value,
  input  logic signed [sli_pkg::VALUE_W-1:0]  upd_value,
  input  sli_pkg::cell_cmd_t                  cmd,
  input  logic                                left_below,
  input  logic signed [sli_pkg::VALUE_W-1:0]  left_entry,
  input  logic signed [sli_pkg::VALUE_W-1:0]  right_entry,
  output logic                                below,
  output logic                                hit,
  output logic signed [sli_pkg::VALUE_W-1:0]  entry
);
  import sli_pkg::*;

  logic is_eq;

  // Capture the compare against the incoming word.
  always_ff @(posedge clk) begin
    if (cmp_en) begin
      below <= occupied && (entry < value);
      is_eq <= occupied && (entry == value);
    end
  end

  // First slot not below the value, holding an equal entry.
  assign hit = is_eq && !below && left_below;

  always_ff @(posedge clk) begin
    if (!below) begin
      if (cmd.ins) begin
        entry <= left_below ? upd_value : left_entry;
      end else if (cmd.del) begin
        entry <= right_entry;
      end
    end
  end

endmodule

// ===== src/sorted_list_insert_delete_top.sv =====
// Top level of the sorted list: control, count and the chain of entry cells.
// The accepting edge moves the control into the update state, where the cell
// chain shifts; done and the result word are registered at the update edge.
// No new request is taken while busy (the update state).
// Reset clears the count and the control; stored entries are not cleared.
// The result is shown for one cycle; the receiver cannot stall it.
module sorted_list_insert_delete_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                req_type,
  input  logic signed [sli_pkg::VALUE_W-1:0]  value,
  output logic                                done,
  output logic [2:0]                          status,
  output logic [sli_pkg::TOTAL_W-1:0]         entry_total
);
  import sli_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_UPD  = 2'b10
  } state_t;

  state_t                    state, state_next;
  logic                      accept;
  logic                      req_q;
  logic signed [VALUE_W-1:0] value_q;
  logic [CNT_W-1:0]          entry_count, entry_count_next;
  logic [DEPTH-1:0]          occ, below, hit;
  logic signed [VALUE_W-1:0] entry [DEPTH];
  logic                      found, full, empty;
  cell_cmd_t                 cmd;
  status_t                   status_next;

  assign accept = start && !busy;
  assign busy   = (state == S_UPD);

  // Hold the request word for the update cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q   <= req_type;
      value_q <= value;
    end
  end

  always_comb begin
    unique case (state)
      S_IDLE:  state_next = accept ? S_UPD : S_IDLE;
      S_UPD:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Occupancy thermometer from the count; stable from compare to update.
  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_occ
      assign occ[i] = (CNT_W'(i) < entry_count);
    end
  endgenerate

  assign found = |hit;
  assign full  = (entry_count == CNT_W'(DEPTH));
  assign empty = (entry_count == '0);

  // Drive the chain only when the request really changes the list.
  assign cmd.ins = busy && (req_q == REQ_INSERT) && !full;
  assign cmd.del = busy && (req_q == REQ_DELETE) && found;

  always_comb begin
    entry_count_next = entry_count;
    status_next      = ST_INSERTED;
    if (req_q == REQ_INSERT) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        status_next      = ST_INSERTED;
        entry_count_next = entry_count + CNT_W'(1);
      end
    end else begin
      priority if (empty) begin
        status_next = ST_EMPTY;
      end else if (found) begin
        status_next      = ST_DELETED;
        entry_count_next = entry_count - CNT_W'(1);
      end else begin
        status_next = ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      done <= busy;
      if (busy) begin
        entry_count <= entry_count_next;
      end
    end
  end

  // Result word: register it at the update edge.
  always_ff @(posedge clk) begin
    if (busy) begin
      status      <= status_next;
      entry_total <= TOTAL_W'(entry_count_next);
    end
  end

  // Cell chain: cell 0 sees an always-below left neighbor, the last cell
  // pulls its own entry when the tail shifts left.
  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                      lb;
      logic signed [VALUE_W-1:0] le, re;
      if (i == 0) begin : g_first
        assign lb = 1'b1;
        assign le = value_q;
      end else begin : g_mid_l
        assign lb = below[i-1];
        assign le = entry[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign re = entry[i];
      end else begin : g_mid_r
        assign re = entry[i+1];
      end
      sli_cell u_cell (
        .clk         (clk),
        .cmp_en      (accept),
        .occupied    (occ[i]),
        .value       (value),
        .upd_value   (value_q),
        .cmd         (cmd),
        .left_below  (lb),
        .left_entry  (le),
        .right_entry (re),
        .below       (below[i]),
        .hit         (hit[i]),
        .entry       (entry[i])
      );
    end
  endgenerate

endmodule

// ===== src/sli_checker.sv =====
// Port-level timing checks of the sorted list top level, with its bind.
module sli_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic [2:0]                  status,
  input logic [sli_pkg::TOTAL_W-1:0] entry_total
);
  import sli_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy))
    else $error("update cycle did not deliver a result");

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request");

  a_total_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (entry_total <= TOTAL_W'(DEPTH)))
    else $error("entry total beyond depth");

  a_full_total: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_FULL)) |-> (entry_total == TOTAL_W'(DEPTH)))
    else $error("full status with a short list");

endmodule

bind sorted_list_insert_delete_top sli_checker u_sli_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .entry_total (entry_total)
);

// ===== verif/testbench.sv =====
// Testbench for the sorted list block: shadow list scoreboard, paced request driver, result monitor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sli_pkg::*;

  // One word's worth of expected outcome, kept with the request that caused it
  // so a mismatch report can name the request.
  typedef struct {
    req_t                       req;
    logic signed [VALUE_W-1:0]  val;
    status_t                    st;
    logic [TOTAL_W-1:0]         total;
  } list_outcome_t;

  // Shadow copy of the list plus the queue of outcomes still owed by the block.
  class list_shadow;
    logic signed [VALUE_W-1:0] shelf [DEPTH];
    int                        fill;
    list_outcome_t             owed [$];
    int                        failures;
    int                        results_seen;
    int                        words_noted;
    int                        status_hits [5];

    function new();
      fill = 0;
      failures = 0;
      results_seen = 0;
      words_noted = 0;
      foreach (status_hits[k]) status_hits[k] = 0;
    endfunction

    // Apply one accepted word to the shadow list and queue its outcome.
    function void note_request(req_t r, logic signed [VALUE_W-1:0] v);
      list_outcome_t o;
      int pos;
      int i;
      o.req = r;
      o.val = v;
      pos = 0;
      if (r == REQ_INSERT) begin
        if (fill >= DEPTH) begin
          o.st = ST_FULL;
        end else begin
          // New value goes ahead of any equal entries.
          while (pos < fill && shelf[pos] < v) pos++;
          for (i = fill; i > pos; i--) shelf[i] = shelf[i - 1];
          shelf[pos] = v;
          fill++;
          o.st = ST_INSERTED;
        end
      end else if (fill == 0) begin
        o.st = ST_EMPTY;
      end else begin
        while (pos < fill && shelf[pos] != v) pos++;
        if (pos >= fill) begin
          o.st = ST_NOT_FOUND;
        end else begin
          for (i = pos; i + 1 < fill; i++) shelf[i] = shelf[i + 1];
          fill--;
          o.st = ST_DELETED;
        end
      end
      o.total = fill[TOTAL_W-1:0];
      status_hits[o.st]++;
      words_noted++;
      owed.push_back(o);
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("MISMATCH: %s", msg);
    endfunction

    // Compare one result word with the oldest owed outcome, field by field.
    function void check_result(logic [2:0] st, logic [TOTAL_W-1:0] total);
      list_outcome_t o;
      results_seen++;
      if (owed.size() == 0) begin
        note_failure($sformatf("result status %0d entry_total %0d with no request pending",
                               st, total));
        return;
      end
      o = owed.pop_front();
      if (st !== o.st || total !== o.total)
        note_failure($sformatf("%s %0d: status exp %s(%0d) got %0d, entry_total exp %0d got %0d",
                               o.req.name(), o.val, o.st.name(), o.st, st, o.total, total));
    endfunction

    // Anything still owed at the end was never answered.
    function void close_out();
      if (owed.size() != 0)
        note_failure($sformatf("%0d results never arrived", owed.size()));
      failures += (owed.size() > 1) ? owed.size() - 1 : 0;
    endfunction
  endclass

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic                       req_type = 1'b0;
  logic signed [VALUE_W-1:0]  value = '0;
  logic                       done;
  logic [2:0]                 status;
  logic [TOTAL_W-1:0]         entry_total;

  list_shadow sb = new();

  // Sender pacing: words go out in bursts, with idle gaps in between.
  int burst_left = 0;

  sorted_list_insert_delete_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .value       (value),
    .done        (done),
    .status      (status),
    .entry_total (entry_total)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block stops answering or never drops busy.
  initial begin
    #3_000_000;
    $display("Timeout: block stopped responding");
    $display("Test completed with failures");
    $finish;
  end

  // Sample results at the edge that ends the strobe cycle; values read here
  // are the ones settled before the edge.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(status, entry_total);
  end

  // After an accepted word, either keep start high for the next word or
  // drop it for a gap. Start is touched only once per edge.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    // Mix long back-to-back stretches with short bursts.
    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Present one word, hold it until the block takes it, then log it.
  task automatic issue_request(input req_t r, input logic signed [VALUE_W-1:0] v);
    start    <= 1'b1;
    req_type <= r;
    value    <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Accepted at this edge: start was high and busy low just before it.
    sb.note_request(r, v);
    pace_sender();
  endtask

  // Draw a value: extremes, a small crowded pool to force duplicates, or anything.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh0000_0000;
          default: return 32'shffff_ffff;
        endcase
      end
      1, 2, 3: return $signed(32'($urandom_range(0, 15))) - 32'sd8;
      default: return $signed($urandom());
    endcase
  endfunction

  // Deletes mostly hit a stored entry, so the list actually drains.
  function automatic logic signed [VALUE_W-1:0] pick_delete_value();
    if (sb.fill > 0 && $urandom_range(0, 99) < 70)
      return sb.shelf[$urandom_range(0, sb.fill - 1)];
    return pick_value();
  endfunction

  initial begin
    int n;
    int insert_bias;
    int settle;
    int biases [5];
    biases = '{10, 40, 55, 85, 97};
    insert_bias = 50;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: delete from the empty list, zero handling, extremes, duplicates.
    issue_request(REQ_DELETE, 32'sd0);
    issue_request(REQ_INSERT, 32'sd0);
    issue_request(REQ_INSERT, 32'sh8000_0000);
    issue_request(REQ_INSERT, 32'sh7fff_ffff);
    issue_request(REQ_INSERT, -32'sd1);
    issue_request(REQ_INSERT, 32'sd1);
    issue_request(REQ_INSERT, 32'sd0);
    issue_request(REQ_DELETE, 32'sd0);
    issue_request(REQ_DELETE, 32'sd0);
    // Zero is gone now: must come back as not found.
    issue_request(REQ_DELETE, 32'sd0);
    issue_request(REQ_DELETE, 32'sd12345);
    // Fill to the brim, then push once more into the full list.
    while (sb.fill < DEPTH) issue_request(REQ_INSERT, pick_value());
    issue_request(REQ_INSERT, 32'sd0);
    issue_request(REQ_DELETE, sb.shelf[DEPTH - 1]);
    issue_request(REQ_DELETE, sb.shelf[0]);

    // Random: the insert bias drifts so the list swings between empty and full.
    for (n = 0; n < 1600; n++) begin
      if (n % 48 == 0) insert_bias = biases[$urandom_range(0, 4)];
      if ($urandom_range(0, 99) < insert_bias)
        issue_request(REQ_INSERT, pick_value());
      else
        issue_request(REQ_DELETE, pick_delete_value());
    end
    start <= 1'b0;

    // Drain: wait for every owed result, bounded, then idle before the close-out.
    settle = 0;
    while (sb.owed.size() != 0 && settle < 1000) begin
      @(posedge clk);
      settle++;
    end
    repeat (8) @(posedge clk);
    sb.close_out();

    $display("Ran %0d requests, %0d results checked, %0d failures.",
             sb.words_noted, sb.results_seen, sb.failures);
    $display("Statuses: inserted %0d, deleted %0d, not found %0d, full %0d, empty %0d.",
             sb.status_hits[ST_INSERTED], sb.status_hits[ST_DELETED],
             sb.status_hits[ST_NOT_FOUND], sb.status_hits[ST_FULL], sb.status_hits[ST_EMPTY]);
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sorted_list_insert_delete_top.f =====
src/sli_pkg.sv
src/sli_cell.sv
src/sorted_list_insert_delete_top.sv
src/sli_checker.sv
verif/testbench.sv
